[hw/rtl/hll_pkg.sv]
// ----------------------------------------------------------------------------
// hll_pkg
// shared constants, types and helper functions for the hyperloglog register
// file
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int MAX_BUCKET_BITS = 16;
  localparam int MIN_BUCKET_BITS = 4;
  localparam int BITS_W          = 5;
  localparam int REG_W           = 5;
  localparam int HASH_W          = 32;
  localparam int IDX_W           = MAX_BUCKET_BITS;
  localparam int SUM_W           = 49;
  localparam int EMPTY_W         = 17;
  localparam int FRAC_W          = 32;
  localparam int IN_DATA_W       = 56;
  localparam int OUT_DATA_W      = 88;

  localparam logic [REG_W-1:0]  MAX_REG_VALUE = REG_W'(29);
  localparam logic [BITS_W-1:0] BITS_RESET    = BITS_W'(MIN_BUCKET_BITS);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
    logic clr_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

  // leading zero count, input never zero
  function automatic logic [4:0] clz32(input logic [HASH_W-1:0] v_in);
    logic [HASH_W-1:0] v;
    logic [4:0]        n;
    v = v_in;
    n = '0;
    if (v[31:16] == '0) begin
      n = n + 5'd16;
      v = {v[15:0], 16'd0};
    end
    if (v[31:24] == '0) begin
      n = n + 5'd8;
      v = {v[23:0], 8'd0};
    end
    if (v[31:28] == '0) begin
      n = n + 5'd4;
      v = {v[27:0], 4'd0};
    end
    if (v[31:30] == '0) begin
      n = n + 5'd2;
      v = {v[29:0], 2'd0};
    end
    if (!v[31]) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

  // 2^-r with FRAC_W fractional bits
  function automatic logic [SUM_W-1:0] weight_of(input logic [REG_W-1:0] r);
    return SUM_W'(1) << (6'(FRAC_W) - {1'b0, r});
  endfunction

endpackage

[hw/rtl/hll_ctrl.sv]
// ----------------------------------------------------------------------------
// hll_ctrl
// sequencer for the hyperloglog register file: init sweep, read, update,
// clear sweep and result handshake
// ----------------------------------------------------------------------------
module hll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  hll_pkg::op_t       in_op,
  output logic               out_tvalid,
  input  logic               out_tready,
  output hll_pkg::dp_cmd_t   dp_cmd,
  input  hll_pkg::dp_status_t dp_status
);
  import hll_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (dp_status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_NOP:   state_nxt = ST_UPDATE;
            default:  state_nxt = ST_READ;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (dp_status.clr_last) state_nxt = ST_UPDATE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    dp_cmd         = '0;
    case (state_r)
      ST_INIT: begin
        dp_cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_tready      = 1'b1;
        dp_cmd.capture = in_tvalid;
      end
      ST_READ: begin
        dp_cmd.rd_en = 1'b1;
      end
      ST_UPDATE: begin
        dp_cmd.commit = out_free;
      end
      ST_CLEAR: begin
        dp_cmd.clr_wr = 1'b1;
      end
      default: begin
        dp_cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/hll_dpath.sv]
// ----------------------------------------------------------------------------
// hll_dpath
// bucket store, rank and merge decode, running harmonic sum and empty count,
// result register
// ----------------------------------------------------------------------------
module hll_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_tvalid,
  output logic                              cfg_tready,
  input  logic [hll_pkg::BITS_W-1:0]        cfg_tdata,
  input  hll_pkg::op_t                      in_op,
  input  logic [hll_pkg::HASH_W-1:0]        in_hash,
  input  logic [hll_pkg::IDX_W-1:0]         in_bucket,
  input  logic [hll_pkg::REG_W-1:0]         in_reg_value,
  output logic [hll_pkg::SUM_W-1:0]         out_sum,
  output logic [hll_pkg::EMPTY_W-1:0]       out_empty,
  output logic [hll_pkg::IDX_W-1:0]         out_bucket,
  output logic [hll_pkg::REG_W-1:0]         out_reg_value,
  input  hll_pkg::dp_cmd_t                  dp_cmd,
  output hll_pkg::dp_status_t               dp_status
);
  import hll_pkg::*;

  logic [REG_W-1:0]   mem [2**IDX_W];

  logic [BITS_W-1:0]  idx_bits_r;
  logic [BITS_W-1:0]  p_act;
  logic [IDX_W-1:0]   mask;
  logic [HASH_W-1:0]  rank_src;
  logic [REG_W-1:0]   rank;
  logic [REG_W-1:0]   merge_val;

  op_t                op_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [REG_W-1:0]   val_r, val_nxt;
  logic [REG_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]   clr_cnt_r;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [EMPTY_W-1:0] empty_r, empty_nxt;
  logic [SUM_W-1:0]   out_sum_r;
  logic [EMPTY_W-1:0] out_empty_r;
  logic [IDX_W-1:0]   out_bucket_r;
  logic [REG_W-1:0]   out_reg_value_r;
  logic [REG_W-1:0]   touched_val;

  logic               is_update;
  logic               raise;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [REG_W-1:0]   mem_wdata;

  assign cfg_tready = 1'b1;

  always_comb begin
    if (idx_bits_r < BITS_W'(MIN_BUCKET_BITS)) begin
      p_act = BITS_W'(MIN_BUCKET_BITS);
    end else if (idx_bits_r > BITS_W'(MAX_BUCKET_BITS)) begin
      p_act = BITS_W'(MAX_BUCKET_BITS);
    end else begin
      p_act = idx_bits_r;
    end
  end

  assign mask      = IDX_W'(((IDX_W+1)'(1) << p_act) - (IDX_W+1)'(1));
  assign rank_src  = in_hash | {{(HASH_W-IDX_W){1'b0}}, mask};
  assign rank      = clz32(rank_src) + REG_W'(1);
  assign merge_val = (in_reg_value > MAX_REG_VALUE) ? MAX_REG_VALUE : in_reg_value;

  always_comb begin
    idx_nxt = '0;
    val_nxt = '0;
    case (in_op)
      OP_ADD: begin
        idx_nxt = in_hash[IDX_W-1:0] & mask;
        val_nxt = rank;
      end
      OP_MERGE: begin
        idx_nxt = in_bucket & mask;
        val_nxt = merge_val;
      end
      default: begin
        idx_nxt = '0;
        val_nxt = '0;
      end
    endcase
  end

  assign is_update   = (op_r == OP_ADD) || (op_r == OP_MERGE);
  assign raise       = is_update && (val_r > rd_data_r);
  assign touched_val = !is_update ? '0 : (raise ? val_r : rd_data_r);

  always_comb begin
    sum_nxt   = sum_r;
    empty_nxt = empty_r;
    if (op_r == OP_CLEAR) begin
      sum_nxt   = SUM_W'(1) << (6'(FRAC_W) + {1'b0, p_act});
      empty_nxt = EMPTY_W'(1) << p_act;
    end else if (raise) begin
      sum_nxt = sum_r - weight_of(rd_data_r) + weight_of(val_r);
      if (rd_data_r == '0) begin
        empty_nxt = empty_r - EMPTY_W'(1);
      end
    end
  end

  assign dp_status.clr_last = &clr_cnt_r;

  assign mem_we    = dp_cmd.clr_wr || (dp_cmd.commit && raise);
  assign mem_waddr = dp_cmd.clr_wr ? clr_cnt_r : idx_r;
  assign mem_wdata = dp_cmd.clr_wr ? '0 : val_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (dp_cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_bits_r <= BITS_RESET;
      clr_cnt_r  <= '0;
      sum_r      <= SUM_W'(1) << (FRAC_W + MIN_BUCKET_BITS);
      empty_r    <= EMPTY_W'(1) << MIN_BUCKET_BITS;
      op_r       <= OP_NOP;
    end else begin
      if (cfg_tvalid) begin
        idx_bits_r <= cfg_tdata;
      end
      if (dp_cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (dp_cmd.capture) begin
        op_r <= in_op;
      end
      if (dp_cmd.commit) begin
        sum_r   <= sum_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      idx_r <= idx_nxt;
      val_r <= val_nxt;
    end
    if (dp_cmd.commit) begin
      out_sum_r       <= sum_nxt;
      out_empty_r     <= empty_nxt;
      out_bucket_r    <= is_update ? idx_r : '0;
      out_reg_value_r <= touched_val;
    end
  end

  assign out_sum       = out_sum_r;
  assign out_empty     = out_empty_r;
  assign out_bucket    = out_bucket_r;
  assign out_reg_value = out_reg_value_r;

endmodule

[hw/rtl/hyperloglog_register_file.sv]
// ----------------------------------------------------------------------------
// hyperloglog_register_file
// hyperloglog bucket store with running harmonic sum and empty bucket count
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tuser command, tdata hash/bucket/value
//   out_     out  out_tvalid/out_tready tdata sum/empty/bucket/value
//   cfg_     in   cfg_tvalid/cfg_tready tdata log2 of bucket count
//
// add and merge step through accept, store read, update and result
// the unused command skips the store read
// clear sweeps all 65536 store entries, one per cycle, then gives its result
// after reset all 65536 store entries are swept to zero with in_tready low
// the next word is accepted while a result still waits on out_tready
// the update step holds until the result register is free
// ----------------------------------------------------------------------------
module hyperloglog_register_file (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [1:0]                          in_tuser,  // command
  // hash_value, bucket_index, register_value, zero pad
  input  logic [hll_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // harmonic_sum, empty_count, touched_bucket, touched_value, zero pad
  output logic [hll_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  input  logic [hll_pkg::BITS_W-1:0]          cfg_tdata  // log2 of bucket count
);
  import hll_pkg::*;

  op_t                in_op;
  dp_cmd_t            dp_cmd;
  dp_status_t         dp_status;
  logic [SUM_W-1:0]   out_sum;
  logic [EMPTY_W-1:0] out_empty;
  logic [IDX_W-1:0]   out_bucket;
  logic [REG_W-1:0]   out_reg_value;

  assign in_op = op_t'(in_tuser);

  hll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status)
  );

  hll_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_tvalid    (cfg_tvalid),
    .cfg_tready    (cfg_tready),
    .cfg_tdata     (cfg_tdata),
    .in_op         (in_op),
    .in_hash       (in_tdata[31:0]),
    .in_bucket     (in_tdata[47:32]),
    .in_reg_value  (in_tdata[52:48]),
    .out_sum       (out_sum),
    .out_empty     (out_empty),
    .out_bucket    (out_bucket),
    .out_reg_value (out_reg_value),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status)
  );

  assign out_tdata = {1'b0, out_reg_value, out_bucket, out_empty, out_sum};

endmodule

[bench/tb_hyperloglog_register_file.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hyperloglog_register_file
// Self-checking bench for the hyperloglog bucket store. A local mirror of the
// buckets, the harmonic sum and the empty count predicts every result word.
// Directed corners cover ranks, merge saturation, clear, the unused command
// and index width changes with and without clear. Mixed random traffic runs
// over several index widths with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_hyperloglog_register_file;
  import hll_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int STORE_DEPTH    = 1 << MAX_BUCKET_BITS;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [REG_W-1:0]   value;
    logic [IDX_W-1:0]   bucket;
    logic [EMPTY_W-1:0] empty;
    logic [SUM_W-1:0]   sum;
  } snapshot_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [1:0]            in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_tvalid;
  logic                  cfg_tready;
  logic [BITS_W-1:0]     cfg_tdata;

  hyperloglog_register_file DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // sketch mirror
  logic [REG_W-1:0]   bucket_mirror [STORE_DEPTH];
  logic [SUM_W-1:0]   sum_mirror;
  logic [EMPTY_W-1:0] empty_mirror;
  logic [BITS_W-1:0]  bits_mirror;
  snapshot_t          sketch_snapshots [$];

  int error_count   = 0;
  int checked_count = 0;
  int cfg_count     = 0;
  int idle_cycles   = 0;
  int op_count [4]  = '{default: 0};

  int burst_left   = 0;
  bit no_gaps      = 1'b0;
  bit hold_request = 1'b0;
  int ready_mode   = 1;

  function automatic int clamp_bits(input logic [BITS_W-1:0] b);
    if (b < MIN_BUCKET_BITS) return MIN_BUCKET_BITS;
    if (b > MAX_BUCKET_BITS) return MAX_BUCKET_BITS;
    return int'(b);
  endfunction

  // leading zeros plus one, input always has low bits set
  function automatic logic [REG_W-1:0] hash_rank(input logic [HASH_W-1:0] v);
    int zeros;
    zeros = 0;
    while (!v[HASH_W-1-zeros]) zeros++;
    return REG_W'(zeros + 1);
  endfunction

  function automatic void raise_bucket(input logic [IDX_W-1:0] idx,
                                       input logic [REG_W-1:0] r);
    logic [REG_W-1:0] old;
    old = bucket_mirror[idx];
    if (r > old) begin
      sum_mirror = sum_mirror - (SUM_W'(1) << (FRAC_W - int'(old)))
                              + (SUM_W'(1) << (FRAC_W - int'(r)));
      if (old == '0) empty_mirror = empty_mirror - EMPTY_W'(1);
      bucket_mirror[idx] = r;
    end
  endfunction

  function automatic snapshot_t advance_sketch(input op_t op,
                                               input logic [IN_DATA_W-1:0] word);
    int                p;
    logic [HASH_W-1:0] mask;
    logic [IDX_W-1:0]  idx;
    logic [REG_W-1:0]  val;
    snapshot_t         s;
    p    = clamp_bits(bits_mirror);
    mask = (HASH_W'(1) << p) - HASH_W'(1);
    s    = '0;
    case (op)
      OP_ADD: begin
        idx = IDX_W'(word[HASH_W-1:0] & mask);
        raise_bucket(idx, hash_rank(word[HASH_W-1:0] | mask));
        s.bucket = idx;
        s.value  = bucket_mirror[idx];
      end
      OP_MERGE: begin
        idx = word[HASH_W +: IDX_W] & IDX_W'(mask);
        val = word[HASH_W+IDX_W +: REG_W];
        if (val > MAX_REG_VALUE) val = MAX_REG_VALUE;
        raise_bucket(idx, val);
        s.bucket = idx;
        s.value  = bucket_mirror[idx];
      end
      OP_CLEAR: begin
        foreach (bucket_mirror[i]) bucket_mirror[i] = '0;
        sum_mirror   = SUM_W'(1) << (p + FRAC_W);
        empty_mirror = EMPTY_W'(1) << p;
      end
      default: ;
    endcase
    s.sum   = sum_mirror;
    s.empty = empty_mirror;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch %0d at %0t: %s got %0h expected %0h",
               error_count, $realtime, what, got, want);
  endtask

  // result check, prediction and watchdog
  always @(posedge clk) begin
    snapshot_t got;
    snapshot_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = snapshot_t'(out_tdata[$bits(snapshot_t)-1:0]);
        if (sketch_snapshots.size() == 0) begin
          report_mismatch("unexpected word, sum", 64'(got.sum), '0);
        end else begin
          want = sketch_snapshots.pop_front();
          checked_count++;
          if (got.sum != want.sum)
            report_mismatch("harmonic_sum", 64'(got.sum), 64'(want.sum));
          if (got.empty != want.empty)
            report_mismatch("empty_count", 64'(got.empty), 64'(want.empty));
          if (got.bucket != want.bucket)
            report_mismatch("touched_bucket", 64'(got.bucket), 64'(want.bucket));
          if (got.value != want.value)
            report_mismatch("touched_value", 64'(got.value), 64'(want.value));
        end
      end
      if (cfg_tvalid && cfg_tready) begin
        bits_mirror = cfg_tdata;
        cfg_count++;
      end
      if (in_tvalid && in_tready) begin
        sketch_snapshots.push_back(advance_sketch(op_t'(in_tuser), in_tdata));
        op_count[in_tuser]++;
      end
      if ((out_tvalid && out_tready) || (cfg_tvalid && cfg_tready) ||
          (in_tvalid && in_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // receiver
  initial begin
    int tick;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ((tick % 7) < 4);
      endcase
    end
  end

  task automatic push_word(input op_t op, input logic [HASH_W-1:0] hash,
                           input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({val, idx, hash});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sketch_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_idx_bits(input logic [BITS_W-1:0] bits);
    wait_for_results();
    @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= bits;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  task automatic test_command_corners();
    ready_mode = 1;
    push_word(OP_NOP, '1, '1, '1);
    push_word(OP_ADD, 32'h0000_0000, '0, '0);
    push_word(OP_ADD, 32'hFFFF_FFFF, '0, '0);
    push_word(OP_ADD, 32'h8000_0000, '0, '0);
    push_word(OP_ADD, 32'h0001_0003, '0, '0);
    push_word(OP_MERGE, '0, 16'hFFFF, 5'd31);
    push_word(OP_MERGE, '0, 16'h0005, 5'd0);
    push_word(OP_MERGE, '0, 16'h0005, 5'd29);
    push_word(OP_MERGE, '0, 16'h0005, 5'd3);
    wait_for_results();
    push_word(OP_CLEAR, '0, '0, '0);
    push_word(OP_ADD, 32'h0000_0010, '0, '0);
    wait_for_results();
  endtask

  task automatic test_idx_bits_changes();
    // above range, no clear: sum and count carry on from the old values
    write_idx_bits(5'd31);
    push_word(OP_ADD, 32'h0000_0000, '0, '0);
    push_word(OP_ADD, 32'hFFFF_FFFF, '0, '0);
    push_word(OP_MERGE, '0, 16'hABCD, 5'd29);
    push_word(OP_CLEAR, '0, '0, '0);
    push_word(OP_ADD, 32'h0000_8000, '0, '0);
    push_word(OP_MERGE, '0, 16'hFFFF, 5'd31);
    // below range, upper buckets keep their contents
    write_idx_bits(5'd0);
    push_word(OP_ADD, 32'h0000_0000, '0, '0);
    push_word(OP_MERGE, '0, 16'h1234, 5'd30);
    push_word(OP_CLEAR, '0, '0, '0);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    int k;
    ready_mode   = 0;
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) begin
      if (k % 2 == 0)
        push_word(OP_ADD, $urandom >> $urandom_range(0, 31), '0, '0);
      else
        push_word(OP_MERGE, '0, IDX_W'($urandom), REG_W'($urandom));
    end
    no_gaps = 1'b0;
    wait_for_results();
  endtask

  task automatic run_mixed_phase(input logic [BITS_W-1:0] bits, input bit start_clear,
                                 input int items, input int mode, input bit clear_midway);
    int                p;
    int                k;
    int                pick;
    logic [HASH_W-1:0] mask;
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  target;
    logic [IDX_W-1:0]  recent [4];
    write_idx_bits(bits);
    ready_mode = mode;
    p    = clamp_bits(bits);
    mask = (HASH_W'(1) << p) - HASH_W'(1);
    foreach (recent[i]) recent[i] = IDX_W'($urandom);
    if (start_clear)
      push_word(OP_CLEAR, $urandom, IDX_W'($urandom), REG_W'($urandom));
    for (k = 0; k < items; k++) begin
      // revisit recent buckets often to hit back to back updates
      if ($urandom_range(0, 1) == 1) target = recent[$urandom_range(0, 3)];
      else target = IDX_W'($urandom);
      recent[k % 4] = target;
      pick = $urandom_range(0, 99);
      if (clear_midway && k == items / 2) begin
        push_word(OP_CLEAR, $urandom, IDX_W'($urandom), REG_W'($urandom));
      end else if (pick < 55) begin
        hash = $urandom >> $urandom_range(0, 31);
        hash = (hash & ~mask) | (HASH_W'(target) & mask);
        push_word(OP_ADD, hash, IDX_W'($urandom), REG_W'($urandom));
      end else if (pick < 90) begin
        push_word(OP_MERGE, $urandom,
                  (IDX_W'($urandom) & ~IDX_W'(mask)) | (target & IDX_W'(mask)),
                  REG_W'($urandom_range(0, 31)));
      end else begin
        push_word(OP_NOP, $urandom, IDX_W'($urandom), REG_W'($urandom));
      end
    end
  endtask

  task automatic test_mixed_traffic();
    run_mixed_phase(5'd16, 1'b1, 130, 1, 1'b0);
    run_mixed_phase(5'd6, 1'b1, 110, 2, 1'b1);
    run_mixed_phase(5'd2, 1'b1, 100, 1, 1'b0);
    no_gaps = 1'b1;
    run_mixed_phase(5'd12, 1'b0, 100, 0, 1'b0);
    no_gaps = 1'b0;
    run_mixed_phase(5'd31, 1'b0, 80, 2, 1'b0);
    wait_for_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    foreach (bucket_mirror[i]) bucket_mirror[i] = '0;
    bits_mirror  = BITS_RESET;
    sum_mirror   = SUM_W'(1) << (MIN_BUCKET_BITS + FRAC_W);
    empty_mirror = EMPTY_W'(1) << MIN_BUCKET_BITS;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_command_corners();
    test_idx_bits_changes();
    test_output_backpressure();
    test_mixed_traffic();
    wait_for_results();

    $display("run: %0d add, %0d merge, %0d clear, %0d unused-command words, %0d config writes",
             op_count[OP_ADD], op_count[OP_MERGE], op_count[OP_CLEAR], op_count[OP_NOP],
             cfg_count);
    $display("run: %0d result words compared, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
